// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the stream hasher unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clk edge while out of reset.
`define CHK_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that trig is followed in the next cycle by res.
`define CHK_NEXT(label, trig, res, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (res)) \
		else $error(msg);

`endif

// ===== rtl/shs_pkg.sv =====
// Package with the SHA-256 constants, round functions and state codes.
`timescale 1ns / 1ps
`default_nettype none
package shs_pkg;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PAD  = 4'b0010,
		ST_COMP = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [7:0] LAST_CNT = 8'd130;

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] v;
		unique case (i)
			3'd0: v = 32'h6a09e667;
			3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372;
			3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f;
			3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab;
			default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] tbl [64];
		tbl = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return tbl[i];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_stream_hasher_unit.sv =====
// Top level of the byte-stream SHA-256 hasher with its schedule memory.
//
// Channel | Direction | Payload                                  | Handshake
// input   | in        | message_byte, has_byte, end_of_message   | in_valid / in_stall
// output  | out       | digest_word, word_index, last_word       | out_valid / out_stall
//
// A data byte is taken while the unit is idle; every 64th byte starts a compression.
// Each round reads its four schedule words as two pairs on the two read ports.
// A closing item adds 1 to 16 padding words (16 more and a second compression when
// the length does not fit), one or two compressions, then 8 words.
// Reset (arst_n low) restores the initial hash values and clears the counters.
// out_stall holds the current digest word; in_stall is high whenever the unit is busy.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha256_stream_hasher_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  message_byte,
	input  wire logic        has_byte,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	import shs_pkg::*;

	// The sixteen 32-bit message and schedule words live in one memory with two
	// registered read ports and one write port.
	logic [31:0] wmem [16];
	logic [3:0]  ra0, ra1, wa;
	logic [31:0] wd;
	logic        we;
	logic [31:0] rd0_q, rd1_q;

	state_t      state_q, after_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] acc_q;
	logic [5:0]  fill_q;
	logic [60:0] total_q;
	logic [7:0]  cnt_q;
	logic [3:0]  ptr_q;
	logic        marked_q, lenfit_q;
	logic [2:0]  idx_q;
	logic [31:0] w2_q, w7_q, w_q;

	logic        take;
	logic [5:0]  fill_nx;
	logic [5:0]  rnd, rnd_m1;
	logic [31:0] w_new, pad_word, t1, t2;
	logic [63:0] bit_len;

	assign in_stall    = (state_q != ST_IDLE);
	assign take        = in_valid && !in_stall;
	assign fill_nx     = fill_q + 6'd1;
	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);
	assign bit_len     = {total_q, 3'b000};

	// Round numbering follows the cycle counter: reads for round r are issued at
	// counts 2r and 2r+1, the schedule word is formed at 2r+2, the round at 2r+3.
	assign rnd    = cnt_q[6:1];
	assign rnd_m1 = rnd - 6'd1;

	// Word written during padding: the first holds the leftover bytes and the
	// marker, the length goes in the last two words of the final block.
	always_comb begin
		pad_word = '0;
		if (!marked_q) begin
			unique case (fill_q[1:0])
				2'd0: pad_word = {PAD_BYTE, 24'h0};
				2'd1: pad_word = {acc_q[7:0], PAD_BYTE, 16'h0};
				2'd2: pad_word = {acc_q[15:0], PAD_BYTE, 8'h0};
				default: pad_word = {acc_q[23:0], PAD_BYTE};
			endcase
		end else if (lenfit_q && ptr_q == 4'd14) begin
			pad_word = bit_len[63:32];
		end else if (lenfit_q && ptr_q == 4'd15) begin
			pad_word = bit_len[31:0];
		end
	end

	// Schedule word from the second read pair (w15 on port 0, w16 on port 1).
	always_comb begin
		if (rnd_m1[5:4] == 2'b00) begin
			w_new = rd1_q;
		end else begin
			w_new = sig1(w2_q) + w7_q + sig0(rd0_q) + rd1_q;
		end
	end

	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ round_k(rnd_m1) + w_q;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	// Memory port control.
	always_comb begin
		we  = 1'b0;
		wa  = '0;
		wd  = '0;
		ra0 = '0;
		ra1 = '0;
		unique case (state_q)
			ST_IDLE: begin
				we = take && has_byte && (fill_q[1:0] == 2'd3);
				wa = fill_q[5:2];
				wd = {acc_q[23:0], message_byte};
			end
			ST_PAD: begin
				we = 1'b1;
				wa = ptr_q;
				wd = pad_word;
			end
			ST_COMP: begin
				if (!cnt_q[0]) begin
					ra0 = rnd[3:0] - 4'd2;
					ra1 = rnd[3:0] - 4'd7;
				end else begin
					ra0 = rnd[3:0] + 4'd1;
					ra1 = rnd[3:0];
				end
				we = !cnt_q[0] && cnt_q >= 8'd2 && cnt_q <= 8'd128;
				wa = rnd_m1[3:0];
				wd = w_new;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			wmem[wa] <= wd;
		end
		rd0_q <= wmem[ra0];
		rd1_q <= wmem[ra1];
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_COMP) begin
			if (cnt_q[0]) begin
				w2_q <= rd0_q;
				w7_q <= rd1_q;
			end
			if (!cnt_q[0] && cnt_q >= 8'd2) begin
				w_q <= w_new;
			end
			if (cnt_q == 8'd0) begin
				for (int i = 0; i < 8; i++) begin
					v_q[i] <= h_q[i];
				end
			end else if (cnt_q[0] && cnt_q >= 8'd3) begin
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
		end
		if (take && has_byte) begin
			acc_q <= {acc_q[23:0], message_byte};
		end
	end

	// Control state and chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			after_q  <= ST_IDLE;
			fill_q   <= '0;
			total_q  <= '0;
			cnt_q    <= '0;
			ptr_q    <= '0;
			marked_q <= 1'b0;
			lenfit_q <= 1'b0;
			idx_q    <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= init_h(3'(i));
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (has_byte) begin
							fill_q  <= fill_nx;
							total_q <= total_q + 61'd1;
						end
						if (has_byte && fill_q == 6'd63) begin
							// A full block compresses first; a closing item pads afterwards.
							state_q  <= ST_COMP;
							cnt_q    <= '0;
							after_q  <= end_of_message ? ST_PAD : ST_IDLE;
							ptr_q    <= '0;
							marked_q <= 1'b0;
							lenfit_q <= 1'b1;
						end else if (end_of_message) begin
							state_q  <= ST_PAD;
							ptr_q    <= has_byte ? fill_nx[5:2] : fill_q[5:2];
							marked_q <= 1'b0;
							lenfit_q <= has_byte ? (fill_nx <= 6'd55) : (fill_q <= 6'd55);
						end
					end
				end
				ST_PAD: begin
					marked_q <= 1'b1;
					ptr_q    <= ptr_q + 4'd1;
					if (ptr_q == 4'd15) begin
						state_q <= ST_COMP;
						cnt_q   <= '0;
						// Without room for the length, a second all-padding block follows.
						after_q <= lenfit_q ? ST_OUT : ST_PAD;
						lenfit_q <= 1'b1;
					end
				end
				ST_COMP: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == LAST_CNT) begin
						for (int i = 0; i < 8; i++) begin
							h_q[i] <= h_q[i] + v_q[i];
						end
						state_q <= after_q;
						fill_q  <= '0;
						idx_q   <= '0;
					end
				end
				default: begin
					if (!out_stall) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= ST_IDLE;
							fill_q  <= '0;
							total_q <= '0;
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= init_h(3'(i));
							end
						end
					end
				end
			endcase
		end
	end

	`CHK_CLK(a_no_overlap, !(out_valid && !in_stall), "input accepted while digest pending")
	`CHK_CLK(a_cnt_range, !(state_q == ST_COMP && cnt_q > LAST_CNT), "round counter overrun")
	`CHK_NEXT(a_last_done, out_valid && last_word && !out_stall, !out_valid && !in_stall,
		"unit did not return to idle after last word")

endmodule
`default_nettype wire

// ===== bench/sha256_stream_hasher_checker.sv =====
// Checker that predicts SHA-256 digests from the byte stream and compares them.
`timescale 1ns / 1ps
module sha256_stream_hasher_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  message_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          words_pending,
	output int          digests_done
);
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	localparam logic [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [31:0] IV_TABLE [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	logic [31:0]  hash_state [8];
	logic [7:0]   blk [64];
	int           blk_fill;
	logic [60:0]  msg_len;
	digest_word_t digest_q [$];

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of blk into hash_state.
	function automatic void compress_blk();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[r] + w[r];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < 8; i++)
			hash_state[i] = IV_TABLE[i];
		blk_fill = 0;
		msg_len = '0;
	endfunction

	// Absorbs one transaction; a closing one pads, compresses and queues the digest.
	function automatic void absorb_item(input logic [7:0] b, input logic h, input logic e);
		int pos;
		logic [63:0] bit_len;
		digest_word_t d;
		if (h) begin
			blk[blk_fill] = b;
			blk_fill++;
			msg_len++;
			if (blk_fill == 64) begin
				compress_blk();
				blk_fill = 0;
			end
		end
		if (!e)
			return;
		bit_len = {msg_len, 3'b000};
		pos = blk_fill;
		blk[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				blk[pos] = 8'h00;
				pos++;
			end
			compress_blk();
			pos = 0;
		end
		while (pos < 56) begin
			blk[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			blk[56+i] = bit_len[63-8*i -: 8];
		compress_blk();
		for (int i = 0; i < 8; i++) begin
			d.word = hash_state[i];
			d.index = 3'(i);
			d.last = (i == 7);
			digest_q.push_back(d);
		end
		restart_hash();
	endfunction

	initial begin
		restart_hash();
		fail_count = 0;
		digests_done = 0;
	end

	assign words_pending = digest_q.size();

	always @(posedge clk) begin
		digest_word_t exp_w;
		if (arst_n) begin
			if (in_valid && !in_stall)
				absorb_item(message_byte, has_byte, end_of_message);
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Unexpected digest word %h index %0d", digest_word, word_index);
				end else begin
					exp_w = digest_q.pop_front();
					if (exp_w != {digest_word, word_index, last_word}) begin
						fail_count++;
						if (fail_count <= 10)
							$display("Digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
								exp_w.word, exp_w.index, exp_w.last,
								digest_word, word_index, last_word);
					end
					if (exp_w.last)
						digests_done++;
				end
			end
		end
	end
endmodule

// ===== bench/sha256_stream_hasher_unit_test.sv =====
// Top of the testbench: drives message bytes into the hasher and gives the verdict.
`timescale 1ns / 1ps
module sha256_stream_hasher_unit_test;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  message_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count;
	int          words_pending;
	int          digests_done;
	int          items_sent = 0;
	// While set, neither side inserts gaps, so back-to-back traffic is covered too.
	logic        no_gaps = 1'b0;

	always #1 clk = ~clk;

	sha256_stream_hasher_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.message_byte(message_byte), .has_byte(has_byte), .end_of_message(end_of_message),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	sha256_stream_hasher_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.message_byte(message_byte), .has_byte(has_byte), .end_of_message(end_of_message),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word),
		.fail_count(fail_count), .words_pending(words_pending), .digests_done(digests_done)
	);

	// Mostly no gap or a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one transaction at a falling edge and holds it until the unit takes it.
	// The payload stays put while in_stall is high.
	task automatic send_item(input logic [7:0] b, input logic h, input logic e);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		message_byte <= b;
		has_byte <= h;
		end_of_message <= e;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Sends a whole message of random bytes. The last byte may carry the end
	// flag itself, or a separate empty closing transaction follows. An idle
	// transaction with neither flag is slipped in now and then as noise.
	task automatic send_message(input int len);
		logic join_end;
		join_end = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, join_end && (i == len - 1));
		end
		if (!join_end)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Receiver side: random stalls, one long hold-off early in the run so that
	// the unit fills up and pushes back on the sender, and quiet stretches.
	initial begin
		int gap;
		int hold_cycles;
		@(posedge arst_n);
		@(negedge clk);
		out_stall <= 1'b1;
		hold_cycles = 0;
		while (hold_cycles < 1500) begin
			@(negedge clk);
			hold_cycles++;
		end
		forever begin
			@(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus. Reset is asserted once, then the directed cases run, then
	// random messages, many with lengths around the padding boundaries.
	initial begin
		int r;
		int len;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty message, an idle transaction, single-byte messages with the end
		// flag on the byte, extreme byte values and a short separately closed one.
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h55, 1'b1, 1'b0);
		send_item(8'haa, 1'b1, 1'b1);

		// Random part: mostly short messages, many at the boundaries where the
		// padding needs a second block, some spanning several blocks.
		while (items_sent < 470) begin
			no_gaps = ($urandom_range(0, 5) == 0);
			r = $urandom_range(0, 99);
			if (r < 55)
				len = $urandom_range(0, 20);
			else if (r < 85)
				len = $urandom_range(53, 66);
			else
				len = $urandom_range(110, 135);
			// The last message is trimmed so the run stays near its item budget.
			if (len > 470 - items_sent)
				len = 470 - items_sent;
			send_message(len);
		end
		no_gaps = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (words_pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);

		$display("Sent %0d transactions; %0d digests checked, including empty and",
			items_sent, digests_done);
		$display("boundary-length messages, idle transactions and a long output hold-off.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#1000000;
		$display("Timeout with %0d digest words outstanding.", words_pending);
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== sha256_stream_hasher_unit.f =====
+incdir+rtl
rtl/shs_pkg.sv
rtl/sha256_stream_hasher_unit.sv
bench/sha256_stream_hasher_checker.sv
bench/sha256_stream_hasher_unit_test.sv
